// File: sv/rvdec_pkg.sv
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and operation codes for the RV32IMAC instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam logic [6:0] K_LUI = 7'd0, K_AUIPC = 7'd1, K_JAL = 7'd2, K_JALR = 7'd3;
  localparam logic [6:0] K_BEQ = 7'd4, K_BNE = 7'd5, K_BLT = 7'd6, K_BGE = 7'd7;
  localparam logic [6:0] K_BLTU = 7'd8, K_BGEU = 7'd9;
  localparam logic [6:0] K_LB = 7'd10, K_LH = 7'd11, K_LW = 7'd12, K_LBU = 7'd13;
  localparam logic [6:0] K_LHU = 7'd14, K_SB = 7'd15, K_SW = 7'd17;
  localparam logic [6:0] K_ADDI = 7'd18, K_SLTI = 7'd19, K_SLTIU = 7'd20, K_XORI = 7'd21;
  localparam logic [6:0] K_ORI = 7'd22, K_ANDI = 7'd23, K_SLLI = 7'd24, K_SRLI = 7'd25;
  localparam logic [6:0] K_SRAI = 7'd26;
  localparam logic [6:0] K_ADD = 7'd27, K_SUB = 7'd28, K_SLL = 7'd29, K_SLT = 7'd30;
  localparam logic [6:0] K_SLTU = 7'd31, K_XOR = 7'd32, K_SRL = 7'd33, K_SRA = 7'd34;
  localparam logic [6:0] K_OR = 7'd35, K_AND = 7'd36;
  localparam logic [6:0] K_FENCE = 7'd37, K_ECALL = 7'd38, K_EBREAK = 7'd39, K_MRET = 7'd40;
  localparam logic [6:0] K_CSRRW = 7'd41, K_CSRRS = 7'd42, K_CSRRC = 7'd43;
  localparam logic [6:0] K_CSRRWI = 7'd44, K_CSRRSI = 7'd45, K_CSRRCI = 7'd46;
  localparam logic [6:0] K_MUL = 7'd47;
  localparam logic [6:0] K_LR_W = 7'd55, K_SC_W = 7'd56, K_AMOSWAP_W = 7'd57;
  localparam logic [6:0] K_AMOADD_W = 7'd58, K_AMOXOR_W = 7'd59, K_AMOAND_W = 7'd60;
  localparam logic [6:0] K_AMOOR_W = 7'd61, K_AMOMIN_W = 7'd62, K_AMOMAX_W = 7'd63;
  localparam logic [6:0] K_AMOMINU_W = 7'd64, K_AMOMAXU_W = 7'd65;

  localparam logic [6:0] OPC_LUI = 7'h37, OPC_AUIPC = 7'h17, OPC_JAL = 7'h6F;
  localparam logic [6:0] OPC_JALR = 7'h67, OPC_BRANCH = 7'h63, OPC_AMO = 7'h2F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73, OPC_FENCE = 7'h0F, OPC_LOAD = 7'h03;
  localparam logic [6:0] OPC_STORE = 7'h23, OPC_OPIMM = 7'h13, OPC_OP = 7'h33;
  localparam logic [11:0] SYS_MRET = 12'h302;
  localparam logic [6:0] F7_ALT = 7'h20;

  typedef struct packed {
    logic        ok;
    logic [6:0]  op_kind;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [2:0]  minor_code;
    logic [6:0]  major_code;
    logic [31:0] imm_value;
    logic        is_short;
    logic [6:0]  major_opcode;
  } dec_t;

endpackage

// File: sv/rvdec_full.sv
// ----------------------------------------------------------------------------
// rvdec_full
// Decodes a 32-bit RV32I/M/A instruction word.
// ----------------------------------------------------------------------------
module rvdec_full (
  input  logic [31:0]         word,
  output rvdec_pkg::dec_t     dec
);
  import rvdec_pkg::*;

  logic [6:0]  op, f7;
  logic [4:0]  rd, rs1, rs2, f5;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic        good;
  logic [6:0]  kind;
  logic [2:0]  form; // 1 R, 2 I, 3 S, 4 B, 5 U, 6 J

  assign op  = word[6:0];
  assign rd  = word[11:7];
  assign f3  = word[14:12];
  assign rs1 = word[19:15];
  assign rs2 = word[24:20];
  assign f7  = word[31:25];
  assign f5  = word[31:27];
  assign imm_i = {{20{word[31]}}, word[31:20]};
  assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_u = {word[31:12], 12'd0};
  assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

  always_comb begin
    good = 1'b1;
    kind = K_LUI;
    form = 3'd0;
    case (op)
      OPC_LUI:   begin kind = K_LUI; form = 3'd5; end
      OPC_AUIPC: begin kind = K_AUIPC; form = 3'd5; end
      OPC_JAL:   begin kind = K_JAL; form = 3'd6; end
      OPC_JALR:  begin kind = K_JALR; form = 3'd2; end
      OPC_FENCE: begin kind = K_FENCE; form = 3'd2; end
      OPC_BRANCH: begin
        form = 3'd4;
        case (f3)
          3'd0: kind = K_BEQ;
          3'd1: kind = K_BNE;
          3'd4: kind = K_BLT;
          3'd5: kind = K_BGE;
          3'd6: kind = K_BLTU;
          3'd7: kind = K_BGEU;
          default: good = 1'b0;
        endcase
      end
      OPC_LOAD: begin
        form = 3'd2;
        case (f3)
          3'd0: kind = K_LB;
          3'd1: kind = K_LH;
          3'd2: kind = K_LW;
          3'd4: kind = K_LBU;
          3'd5: kind = K_LHU;
          default: good = 1'b0;
        endcase
      end
      OPC_STORE: begin
        form = 3'd3;
        good = (f3 <= 3'd2);
        kind = K_SB + {4'd0, f3};
      end
      OPC_OPIMM: begin
        form = 3'd2;
        case (f3)
          3'd0: kind = K_ADDI;
          3'd1: kind = K_SLLI;
          3'd2: kind = K_SLTI;
          3'd3: kind = K_SLTIU;
          3'd4: kind = K_XORI;
          3'd6: kind = K_ORI;
          3'd7: kind = K_ANDI;
          default: begin
            if (f7 == 7'd0) kind = K_SRLI;
            else if (f7 == F7_ALT) kind = K_SRAI;
            else good = 1'b0;
          end
        endcase
      end
      OPC_OP: begin
        form = 3'd1;
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: kind = K_ADD;
            3'd1: kind = K_SLL;
            3'd2: kind = K_SLT;
            3'd3: kind = K_SLTU;
            3'd4: kind = K_XOR;
            3'd5: kind = K_SRL;
            3'd6: kind = K_OR;
            default: kind = K_AND;
          endcase
        end else if (f7 == 7'd1) kind = K_MUL + {4'd0, f3};
        else if (f7 == F7_ALT && f3 == 3'd0) kind = K_SUB;
        else if (f7 == F7_ALT && f3 == 3'd5) kind = K_SRA;
        else good = 1'b0;
      end
      OPC_SYSTEM: begin
        form = 3'd2;
        case (f3)
          3'd0: begin
            if (word[31:20] == 12'd0) kind = K_ECALL;
            else if (word[31:20] == 12'd1) kind = K_EBREAK;
            else if (word[31:20] == SYS_MRET) kind = K_MRET;
            else good = 1'b0;
          end
          3'd1: kind = K_CSRRW;
          3'd2: kind = K_CSRRS;
          3'd3: kind = K_CSRRC;
          3'd5: kind = K_CSRRWI;
          3'd6: kind = K_CSRRSI;
          3'd7: kind = K_CSRRCI;
          default: good = 1'b0;
        endcase
      end
      OPC_AMO: begin
        form = 3'd1;
        if (f3 != 3'd2) good = 1'b0;
        case (f5)
          5'h02: kind = K_LR_W;
          5'h03: kind = K_SC_W;
          5'h01: kind = K_AMOSWAP_W;
          5'h00: kind = K_AMOADD_W;
          5'h04: kind = K_AMOXOR_W;
          5'h0C: kind = K_AMOAND_W;
          5'h08: kind = K_AMOOR_W;
          5'h10: kind = K_AMOMIN_W;
          5'h14: kind = K_AMOMAX_W;
          5'h18: kind = K_AMOMINU_W;
          5'h1C: kind = K_AMOMAXU_W;
          default: good = 1'b0;
        endcase
      end
      default: good = 1'b0;
    endcase
  end

  always_comb begin
    dec = '0;
    if (good) begin
      dec.ok = 1'b1;
      dec.op_kind = kind;
      dec.major_opcode = op;
      case (form)
        3'd1: begin
          dec.dest_reg = rd; dec.src1_reg = rs1; dec.src2_reg = rs2;
          dec.minor_code = f3; dec.major_code = f7;
        end
        3'd2: begin
          dec.dest_reg = rd; dec.src1_reg = rs1; dec.minor_code = f3;
          dec.imm_value = imm_i;
        end
        3'd3: begin
          dec.src1_reg = rs1; dec.src2_reg = rs2; dec.minor_code = f3;
          dec.imm_value = imm_s;
        end
        3'd4: begin
          dec.src1_reg = rs1; dec.src2_reg = rs2; dec.minor_code = f3;
          dec.imm_value = imm_b;
        end
        3'd5: begin dec.dest_reg = rd; dec.imm_value = imm_u; end
        default: begin dec.dest_reg = rd; dec.imm_value = imm_j; end
      endcase
    end
  end

endmodule

// File: sv/rvdec_short.sv
// ----------------------------------------------------------------------------
// rvdec_short
// Expands a 16-bit RV32C compressed word into its base operation.
// ----------------------------------------------------------------------------
module rvdec_short (
  input  logic [15:0]         word,
  output rvdec_pkg::dec_t     dec
);
  import rvdec_pkg::*;

  logic [1:0]  q;
  logic [2:0]  f3;
  logic [4:0]  r5, s5, rp, sp;
  logic [31:0] imm6, imm_j, imm_b, imm_4spn, imm_lw, imm_16sp, imm_lui, imm_lwsp, imm_swsp;
  logic        good;

  assign q  = word[1:0];
  assign f3 = word[15:13];
  assign r5 = word[11:7];
  assign s5 = word[6:2];
  assign rp = {2'b01, word[9:7]};
  assign sp = {2'b01, word[4:2]};
  assign imm6 = {{27{word[12]}}, word[6:2]};
  assign imm_j = {{21{word[12]}}, word[8], word[10:9], word[6], word[7], word[2], word[11],
                  word[5:3], 1'b0};
  assign imm_b = {{24{word[12]}}, word[6:5], word[2], word[11:10], word[4:3], 1'b0};
  assign imm_4spn = {22'd0, word[10:7], word[12:11], word[5], word[6], 2'b00};
  assign imm_lw = {25'd0, word[5], word[12:10], word[6], 2'b00};
  assign imm_16sp = {{23{word[12]}}, word[4:3], word[5], word[2], word[6], 4'd0};
  assign imm_lui = {{15{word[12]}}, word[6:2], 12'd0};
  assign imm_lwsp = {24'd0, word[3:2], word[12], word[6:4], 2'b00};
  assign imm_swsp = {24'd0, word[8:7], word[12:9], 2'b00};

  always_comb begin
    dec = '0;
    good = 1'b1;
    case (q)
      2'd0: begin
        case (f3)
          3'd0: begin
            good = (imm_4spn != 32'd0);
            dec.op_kind = K_ADDI; dec.dest_reg = sp; dec.src1_reg = 5'd2;
            dec.imm_value = imm_4spn;
          end
          3'd2: begin
            dec.op_kind = K_LW; dec.dest_reg = sp; dec.src1_reg = rp;
            dec.imm_value = imm_lw;
          end
          3'd6: begin
            dec.op_kind = K_SW; dec.src2_reg = sp; dec.src1_reg = rp;
            dec.imm_value = imm_lw;
          end
          default: good = 1'b0;
        endcase
      end
      2'd1: begin
        case (f3)
          3'd0: begin
            dec.op_kind = K_ADDI; dec.dest_reg = r5; dec.src1_reg = r5;
            dec.imm_value = imm6;
          end
          3'd1: begin dec.op_kind = K_JAL; dec.dest_reg = 5'd1; dec.imm_value = imm_j; end
          3'd2: begin dec.op_kind = K_ADDI; dec.dest_reg = r5; dec.imm_value = imm6; end
          3'd3: begin
            if (r5 == 5'd2) begin
              good = (imm_16sp != 32'd0);
              dec.op_kind = K_ADDI; dec.dest_reg = 5'd2; dec.src1_reg = 5'd2;
              dec.imm_value = imm_16sp;
            end else begin
              good = (imm_lui != 32'd0) && (r5 != 5'd0);
              dec.op_kind = K_LUI; dec.dest_reg = r5; dec.imm_value = imm_lui;
            end
          end
          3'd4: begin
            dec.dest_reg = rp; dec.src1_reg = rp;
            case (word[11:10])
              2'd0: begin dec.op_kind = K_SRLI; dec.imm_value = {27'd0, s5}; end
              2'd1: begin dec.op_kind = K_SRAI; dec.imm_value = {27'd0, s5}; end
              2'd2: begin dec.op_kind = K_ANDI; dec.imm_value = imm6; end
              default: begin
                dec.src2_reg = sp;
                case (word[6:5])
                  2'd0: dec.op_kind = K_SUB;
                  2'd1: dec.op_kind = K_XOR;
                  2'd2: dec.op_kind = K_OR;
                  default: dec.op_kind = K_AND;
                endcase
              end
            endcase
          end
          3'd5: begin dec.op_kind = K_JAL; dec.imm_value = imm_j; end
          default: begin
            dec.op_kind = (f3 == 3'd6) ? K_BEQ : K_BNE;
            dec.src1_reg = rp; dec.imm_value = imm_b;
          end
        endcase
      end
      default: begin
        case (f3)
          3'd0: begin
            good = (r5 != 5'd0);
            dec.op_kind = K_SLLI; dec.dest_reg = r5; dec.src1_reg = r5;
            dec.imm_value = {27'd0, s5};
          end
          3'd2: begin
            good = (r5 != 5'd0);
            dec.op_kind = K_LW; dec.dest_reg = r5; dec.src1_reg = 5'd2;
            dec.imm_value = imm_lwsp;
          end
          3'd4: begin
            if (s5 != 5'd0) begin
              dec.op_kind = K_ADD; dec.dest_reg = r5; dec.src2_reg = s5;
              if (word[12]) dec.src1_reg = r5;
            end else if (r5 == 5'd0) begin
              if (word[12]) dec.op_kind = K_EBREAK;
              else good = 1'b0;
            end else begin
              dec.op_kind = K_JALR; dec.src1_reg = r5;
              if (word[12]) dec.dest_reg = 5'd1;
            end
          end
          3'd6: begin
            dec.op_kind = K_SW; dec.src1_reg = 5'd2; dec.src2_reg = s5;
            dec.imm_value = imm_swsp;
          end
          default: good = 1'b0;
        endcase
      end
    endcase
    dec.ok = 1'b1;
    dec.is_short = 1'b1;
    dec.major_opcode = {5'd0, q};
    if (!good) dec = '0;
  end

endmodule

// File: sv/rv32imac_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// rv32imac_instruction_decoder_unit
// Streaming RV32IMAC decoder: one instruction word in, one decoded record out.
// ----------------------------------------------------------------------------
// Each accepted word is registered, decoded by combinational logic and the
// result is registered, so its decode appears on the master side once both
// registers have advanced again. Both registers advance together when the
// output register is empty or being drained, and only then is a word taken;
// throughput is one word per cycle while the master side does not stall.
module rv32imac_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // instr_word
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok, op_kind, dest_reg, src1_reg, src2_reg, minor_code, major_code,
  // imm_value, is_short, major_opcode; zero pad to 80 bits
  output logic [79:0] m_tdata
);
  import rvdec_pkg::*;

  logic        in_valid;
  logic [31:0] in_word;
  logic        out_valid;
  dec_t        out_dec;
  dec_t        dec_full, dec_short, dec_next;
  logic        advance;

  rvdec_full u_full (.word(in_word), .dec(dec_full));
  rvdec_short u_short (.word(in_word[15:0]), .dec(dec_short));

  assign dec_next = (in_word[1:0] == 2'b11) ? dec_full : dec_short;
  assign advance  = !out_valid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      in_valid  <= s_tvalid;
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_word <= s_tdata;
      out_dec <= dec_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {7'd0, out_dec.major_opcode, out_dec.is_short, out_dec.imm_value,
                    out_dec.major_code, out_dec.minor_code, out_dec.src2_reg,
                    out_dec.src1_reg, out_dec.dest_reg, out_dec.op_kind, out_dec.ok};

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the RV32IMAC decoder. Words go in on the slave side, and
// each decoded record is checked against a local decode of the same word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rvdec_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // instr_word
  logic        m_tvalid;
  logic        m_tready;
  // ok, op_kind, dest_reg, src1_reg, src2_reg, minor_code, major_code,
  // imm_value, is_short, major_opcode; zero pad to 80 bits
  logic [79:0] m_tdata;

  dec_t decode_q[$];
  int   errors = 0;
  bit   idle_on = 1'b1;
  bit   hold_req = 1'b0;

  typedef enum logic [2:0] {FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J} fmt_e;

  rv32imac_instruction_decoder_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic dec_t decode_full(input logic [31:0] w);
    dec_t d;
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [15:0] c;
    logic [4:0] r5, s5, rp, sp;
    logic [31:0] imm6, v;
    fmt_e fmt;
    bit good;
    d = '0;
    good = 1'b1;
    fmt = FMT_I;
    if (w[1:0] == 2'b11) begin
      op = w[6:0];
      f3 = w[14:12];
      f7 = w[31:25];
      case (op)
        OPC_LUI: begin d.op_kind = K_LUI; fmt = FMT_U; end
        OPC_AUIPC: begin d.op_kind = K_AUIPC; fmt = FMT_U; end
        OPC_JAL: begin d.op_kind = K_JAL; fmt = FMT_J; end
        OPC_JALR: d.op_kind = K_JALR;
        OPC_FENCE: d.op_kind = K_FENCE;
        OPC_BRANCH: begin
          fmt = FMT_B;
          case (f3)
            3'd0: d.op_kind = K_BEQ;
            3'd1: d.op_kind = K_BNE;
            3'd4: d.op_kind = K_BLT;
            3'd5: d.op_kind = K_BGE;
            3'd6: d.op_kind = K_BLTU;
            3'd7: d.op_kind = K_BGEU;
            default: good = 1'b0;
          endcase
        end
        OPC_LOAD: begin
          case (f3)
            3'd0: d.op_kind = K_LB;
            3'd1: d.op_kind = K_LH;
            3'd2: d.op_kind = K_LW;
            3'd4: d.op_kind = K_LBU;
            3'd5: d.op_kind = K_LHU;
            default: good = 1'b0;
          endcase
        end
        OPC_STORE: begin
          fmt = FMT_S;
          if (f3 > 3'd2) good = 1'b0;
          else d.op_kind = K_SB + 7'(f3);
        end
        OPC_OPIMM: begin
          case (f3)
            3'd0: d.op_kind = K_ADDI;
            3'd1: d.op_kind = K_SLLI;
            3'd2: d.op_kind = K_SLTI;
            3'd3: d.op_kind = K_SLTIU;
            3'd4: d.op_kind = K_XORI;
            3'd5: begin
              if (f7 == 7'd0) d.op_kind = K_SRLI;
              else if (f7 == F7_ALT) d.op_kind = K_SRAI;
              else good = 1'b0;
            end
            3'd6: d.op_kind = K_ORI;
            default: d.op_kind = K_ANDI;
          endcase
        end
        OPC_OP: begin
          fmt = FMT_R;
          if (f7 == 7'd0) begin
            case (f3)
              3'd0: d.op_kind = K_ADD;
              3'd1: d.op_kind = K_SLL;
              3'd2: d.op_kind = K_SLT;
              3'd3: d.op_kind = K_SLTU;
              3'd4: d.op_kind = K_XOR;
              3'd5: d.op_kind = K_SRL;
              3'd6: d.op_kind = K_OR;
              default: d.op_kind = K_AND;
            endcase
          end else if (f7 == 7'd1) d.op_kind = K_MUL + 7'(f3);
          else if (f7 == F7_ALT && f3 == 3'd0) d.op_kind = K_SUB;
          else if (f7 == F7_ALT && f3 == 3'd5) d.op_kind = K_SRA;
          else good = 1'b0;
        end
        OPC_SYSTEM: begin
          case (f3)
            3'd0: begin
              if (w[31:20] == 12'h000) d.op_kind = K_ECALL;
              else if (w[31:20] == 12'h001) d.op_kind = K_EBREAK;
              else if (w[31:20] == SYS_MRET) d.op_kind = K_MRET;
              else good = 1'b0;
            end
            3'd1: d.op_kind = K_CSRRW;
            3'd2: d.op_kind = K_CSRRS;
            3'd3: d.op_kind = K_CSRRC;
            3'd5: d.op_kind = K_CSRRWI;
            3'd6: d.op_kind = K_CSRRSI;
            3'd7: d.op_kind = K_CSRRCI;
            default: good = 1'b0;
          endcase
        end
        OPC_AMO: begin
          fmt = FMT_R;
          if (f3 != 3'd2) good = 1'b0;
          else begin
            case (f7[6:2])
              5'h02: d.op_kind = K_LR_W;
              5'h03: d.op_kind = K_SC_W;
              5'h01: d.op_kind = K_AMOSWAP_W;
              5'h00: d.op_kind = K_AMOADD_W;
              5'h04: d.op_kind = K_AMOXOR_W;
              5'h0C: d.op_kind = K_AMOAND_W;
              5'h08: d.op_kind = K_AMOOR_W;
              5'h10: d.op_kind = K_AMOMIN_W;
              5'h14: d.op_kind = K_AMOMAX_W;
              5'h18: d.op_kind = K_AMOMINU_W;
              5'h1C: d.op_kind = K_AMOMAXU_W;
              default: good = 1'b0;
            endcase
          end
        end
        default: good = 1'b0;
      endcase
      d.major_opcode = op;
      case (fmt)
        FMT_R: begin
          d.dest_reg = w[11:7]; d.src1_reg = w[19:15]; d.src2_reg = w[24:20];
          d.minor_code = f3; d.major_code = f7;
        end
        FMT_I: begin
          d.dest_reg = w[11:7]; d.src1_reg = w[19:15]; d.minor_code = f3;
          d.imm_value = {{20{w[31]}}, w[31:20]};
        end
        FMT_S: begin
          d.src1_reg = w[19:15]; d.src2_reg = w[24:20]; d.minor_code = f3;
          d.imm_value = {{20{w[31]}}, w[31:25], w[11:7]};
        end
        FMT_B: begin
          d.src1_reg = w[19:15]; d.src2_reg = w[24:20]; d.minor_code = f3;
          d.imm_value = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        FMT_U: begin
          d.dest_reg = w[11:7]; d.imm_value = {w[31:12], 12'b0};
        end
        default: begin
          d.dest_reg = w[11:7];
          d.imm_value = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
      endcase
    end else begin
      c = w[15:0];
      f3 = c[15:13];
      r5 = c[11:7];
      s5 = c[6:2];
      rp = {2'b01, c[9:7]};
      sp = {2'b01, c[4:2]};
      imm6 = {{26{c[12]}}, c[12], s5};
      d.is_short = 1'b1;
      d.major_opcode = {5'b0, c[1:0]};
      case (c[1:0])
        2'd0: begin
          if (f3 == 3'd0) begin
            v = {22'b0, c[10:7], c[12:11], c[5], c[6], 2'b0};
            if (v == 0) good = 1'b0;
            d.op_kind = K_ADDI; d.dest_reg = sp; d.src1_reg = 5'd2; d.imm_value = v;
          end else if (f3 == 3'd2 || f3 == 3'd6) begin
            d.src1_reg = rp;
            d.imm_value = {25'b0, c[5], c[12:10], c[6], 2'b0};
            if (f3 == 3'd2) begin d.op_kind = K_LW; d.dest_reg = sp; end
            else begin d.op_kind = K_SW; d.src2_reg = sp; end
          end else good = 1'b0;
        end
        2'd1: begin
          case (f3)
            3'd0: begin
              d.op_kind = K_ADDI; d.dest_reg = r5; d.src1_reg = r5; d.imm_value = imm6;
            end
            3'd1, 3'd5: begin
              d.op_kind = K_JAL;
              if (f3 == 3'd1) d.dest_reg = 5'd1;
              d.imm_value = {{20{c[12]}}, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11],
                             c[5:3], 1'b0};
            end
            3'd2: begin d.op_kind = K_ADDI; d.dest_reg = r5; d.imm_value = imm6; end
            3'd3: begin
              if (r5 == 5'd2) begin
                // stack pointer adjust
                v = {{22{c[12]}}, c[12], c[4:3], c[5], c[2], c[6], 4'b0};
                if (v == 0) good = 1'b0;
                d.op_kind = K_ADDI; d.dest_reg = 5'd2; d.src1_reg = 5'd2; d.imm_value = v;
              end else begin
                v = {{14{c[12]}}, c[12], s5, 12'b0};
                if (v == 0 || r5 == 5'd0) good = 1'b0;
                d.op_kind = K_LUI; d.dest_reg = r5; d.imm_value = v;
              end
            end
            3'd4: begin
              d.dest_reg = rp; d.src1_reg = rp;
              case (c[11:10])
                2'd0: begin d.op_kind = K_SRLI; d.imm_value = {27'b0, s5}; end
                2'd1: begin d.op_kind = K_SRAI; d.imm_value = {27'b0, s5}; end
                2'd2: begin d.op_kind = K_ANDI; d.imm_value = imm6; end
                default: begin
                  d.src2_reg = sp;
                  case (c[6:5])
                    2'd0: d.op_kind = K_SUB;
                    2'd1: d.op_kind = K_XOR;
                    2'd2: d.op_kind = K_OR;
                    default: d.op_kind = K_AND;
                  endcase
                end
              endcase
            end
            default: begin
              d.op_kind = (f3 == 3'd6) ? K_BEQ : K_BNE;
              d.src1_reg = rp;
              d.imm_value = {{23{c[12]}}, c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
            end
          endcase
        end
        default: begin
          case (f3)
            3'd0: begin
              if (r5 == 5'd0) good = 1'b0;
              d.op_kind = K_SLLI; d.dest_reg = r5; d.src1_reg = r5;
              d.imm_value = {27'b0, s5};
            end
            3'd2: begin
              if (r5 == 5'd0) good = 1'b0;
              d.op_kind = K_LW; d.dest_reg = r5; d.src1_reg = 5'd2;
              d.imm_value = {24'b0, c[3:2], c[12], c[6:4], 2'b0};
            end
            3'd4: begin
              if (s5 != 5'd0) begin
                d.op_kind = K_ADD; d.dest_reg = r5; d.src2_reg = s5;
                if (c[12]) d.src1_reg = r5;
              end else if (r5 == 5'd0) begin
                if (c[12]) d.op_kind = K_EBREAK;
                else good = 1'b0;
              end else begin
                d.op_kind = K_JALR; d.src1_reg = r5;
                if (c[12]) d.dest_reg = 5'd1;
              end
            end
            3'd6: begin
              d.op_kind = K_SW; d.src1_reg = 5'd2; d.src2_reg = s5;
              d.imm_value = {24'b0, c[8:7], c[12:9], 2'b0};
            end
            default: good = 1'b0;
          endcase
        end
      endcase
    end
    if (!good) d = '0;
    else d.ok = 1'b1;
    return d;
  endfunction

  // 32-bit word on a chosen major opcode with random fields, or a random low half or compressed word
  function automatic logic [31:0] legal_word();
    logic [31:0] w;
    logic [6:0] opcs[10];
    logic [4:0] amo_f5[11];
    logic [6:0] rr_f7[3];
    opcs = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
             OPC_OPIMM, OPC_OP, OPC_AMO};
    amo_f5 = '{5'h02, 5'h03, 5'h01, 5'h00, 5'h04, 5'h0C, 5'h08, 5'h10, 5'h14, 5'h18, 5'h1C};
    rr_f7 = '{7'd0, 7'd1, F7_ALT};
    w = $urandom;
    case ($urandom_range(0, 3))
      0: w[15:0] = 16'($urandom_range(0, 16'hFFFF));
      1: begin
        w[6:0] = opcs[$urandom_range(0, 9)];
        if (w[6:0] == OPC_OP) w[31:25] = rr_f7[$urandom_range(0, 2)];
        if (w[6:0] == OPC_OPIMM && w[14:12] == 3'd5) w[30] = 1'($urandom_range(0, 1));
        if (w[6:0] == OPC_OPIMM && w[14:12] == 3'd5) {w[31], w[29:25]} = '0;
        if (w[6:0] == OPC_AMO) begin
          w[14:12] = 3'd2;
          w[31:27] = amo_f5[$urandom_range(0, 10)];
        end
      end
      2: begin
        w[6:0] = OPC_SYSTEM;
        if (w[14:12] == 3'd0) begin
          case ($urandom_range(0, 2))
            0: w[31:20] = 12'h000;
            1: w[31:20] = 12'h001;
            default: w[31:20] = SYS_MRET;
          endcase
        end
      end
      default: if (w[1:0] == 2'b11) w[1:0] = 2'($urandom_range(0, 2));
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [31:0] w);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = w;
    do @(posedge clk); while (!s_tready);
    decode_q.push_back(decode_full(w));
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    dec_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (decode_q.size() == 0) begin
        $error("unexpected transaction: m_tdata 0x%020h", m_tdata);
        errors++;
      end else begin
        e = decode_q.pop_front();
        check_field("ok", 32'(e.ok), 32'(m_tdata[0]));
        check_field("op_kind", 32'(e.op_kind), 32'(m_tdata[7:1]));
        check_field("dest_reg", 32'(e.dest_reg), 32'(m_tdata[12:8]));
        check_field("src1_reg", 32'(e.src1_reg), 32'(m_tdata[17:13]));
        check_field("src2_reg", 32'(e.src2_reg), 32'(m_tdata[22:18]));
        check_field("minor_code", 32'(e.minor_code), 32'(m_tdata[25:23]));
        check_field("major_code", 32'(e.major_code), 32'(m_tdata[32:26]));
        check_field("imm_value", e.imm_value, m_tdata[64:33]);
        check_field("is_short", 32'(e.is_short), 32'(m_tdata[65]));
        check_field("major_opcode", 32'(e.major_opcode), 32'(m_tdata[72:66]));
        check_field("pad", 32'd0, 32'(m_tdata[79:73]));
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = 300;
      end else n = idle_on ? $urandom_range(0, 18) : 0;
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic test_base_ops();
    logic [31:0] words[12];
    words = '{32'hFFFFF0B7, 32'h00000017, 32'hFFFFF0EF, 32'h0000F067, 32'hFE000EE3,
              32'h7FF12F83, 32'hFE2FAFA3, 32'h40005013, 32'h02005013, 32'hFE0F8033,
              32'h0200F033, 32'h0000007F};
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic test_system_atomic();
    logic [31:0] words[7];
    words = '{32'h00000073, 32'h00100073, 32'h30200073, 32'h00004073, 32'hFFFFF073,
              32'h1E0FAFAF, 32'hE000302F};
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic test_compressed();
    // zero ADDI4SPN, zero LUI, JR x0, EBREAK, SP adjust, J, LWSP x0, full ones
    logic [31:0] words[8];
    words = '{32'h00000000, 32'h00006001, 32'h00008002, 32'hFFFF9002, 32'h00007101,
              32'h0000BFFD, 32'h00004002, 32'hFFFFFFFE};
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      // stretches with no idling on either side
      if (i % 100 == 0) idle_on = (i % 200 == 0);
      send_word(($urandom_range(0, 9) == 0) ? $urandom : legal_word());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_word(legal_word());
    idle_on = 1'b1;
    // sender waits for everything to drain before going on
    s_tvalid = 1'b0;
    wait (decode_q.size() == 0);
    @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_base_ops();
    test_system_atomic();
    test_compressed();
    test_random(300);
    test_backpressure();
    test_random(260);
    s_tvalid = 1'b0;
    wait (decode_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
